// ===== hw/rtl/bls_pkg.sv =====
package bls_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [15:0] SETTLE_RESET  = 16'd20;
    localparam logic [15:0] TRAVEL_RESET  = 16'd100;
    localparam logic [15:0] HOLD_RESET    = 16'd500;
    localparam logic [15:0] PASS_TO_RESET = 16'd2000;
    localparam logic [15:0] REJECT_RESET  = 16'd200;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [15:0]            passes_field_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_IS_ENTRY     = 3'd0,
        REG_CHANNEL      = 3'd1,
        REG_SETTLE       = 3'd2,
        REG_TRAVEL       = 3'd3,
        REG_HOLD         = 3'd4,
        REG_PASS_TIMEOUT = 3'd5,
        REG_REJECT       = 3'd6
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_WAIT    = 4'd1,
        PH_AUTH    = 4'd2,
        PH_REJECT  = 4'd3,
        PH_OPENING = 4'd4,
        PH_OPEN    = 4'd5,
        PH_PASSING = 4'd6,
        PH_CLOSING = 4'd7,
        PH_TIMEOUT = 4'd8
    } phase_t;

    typedef struct packed {
        logic        is_entry_lane;
        logic [3:0]  barrier_channel;
        logic [15:0] settle_ticks;
        logic [15:0] travel_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] pass_limit;
        logic [15:0] reject_dwell;
    } cfg_t;

    typedef struct packed {
        phase_t phase;
        timer_t countdown;
        count_t pass_counter;
        logic   fault_latch;
    } lane_state_t;

    typedef struct packed {
        logic          open_pulse;
        logic          close_pulse;
        logic [3:0]    command_channel;
        logic [3:0]    lane_state;
        passes_field_t passes_done;
        logic          fault;
    } result_t;

    function automatic timer_t load_timer(logic [15:0] ticks);
        return timer_t'(ticks);
    endfunction

endpackage

// ===== hw/rtl/bls_if.sv =====
interface bls_tick_if;
    logic       valid;
    logic       ready;
    logic       loop_present;
    logic [7:0] lot_free_count;

    modport source (output valid, output loop_present, output lot_free_count, input ready);
    modport sink (input valid, input loop_present, input lot_free_count, output ready);
endinterface

interface bls_result_if;
    logic        valid;
    logic        ready;
    logic        open_pulse;
    logic        close_pulse;
    logic [3:0]  command_channel;
    logic [3:0]  lane_state;
    logic [15:0] passes_done;
    logic        fault;

    modport source (output valid, output open_pulse, output close_pulse,
                    output command_channel, output lane_state, output passes_done,
                    output fault, input ready);
    modport sink (input valid, input open_pulse, input close_pulse,
                  input command_channel, input lane_state, input passes_done,
                  input fault, output ready);
endinterface

// ===== hw/rtl/bls_step.sv =====
module bls_step (
    input  bls_pkg::cfg_t        cfg,
    input  bls_pkg::lane_state_t cur,
    input  logic                 loop_present,
    input  logic [7:0]           lot_free_count,
    output bls_pkg::lane_state_t nxt,
    output bls_pkg::result_t     res
);

    bls_pkg::timer_t cd;
    logic            expired;
    logic            lot_full;
    logic            open_p;
    logic            close_p;

    always_comb
    begin
        // shared countdown steps before the sequencer looks at it
        cd       = (cur.countdown != '0) ? cur.countdown - 1'b1 : cur.countdown;
        expired  = (cd == '0);
        lot_full = (lot_free_count == 8'd0);
        open_p   = 1'b0;
        close_p  = 1'b0;

        nxt           = cur;
        nxt.countdown = cd;

        case (cur.phase)
            bls_pkg::PH_IDLE:
            begin
                if (loop_present)
                begin
                    nxt.countdown = bls_pkg::load_timer(cfg.settle_ticks);
                    nxt.phase     = bls_pkg::PH_WAIT;
                end
            end
            bls_pkg::PH_WAIT:
            begin
                if (expired)
                    nxt.phase = bls_pkg::PH_AUTH;
            end
            bls_pkg::PH_AUTH:
            begin
                if (cfg.is_entry_lane && lot_full)
                begin
                    nxt.countdown = bls_pkg::load_timer(cfg.reject_dwell);
                    nxt.phase     = bls_pkg::PH_REJECT;
                end
                else
                begin
                    open_p        = 1'b1;
                    nxt.countdown = bls_pkg::load_timer(cfg.travel_ticks);
                    nxt.phase     = bls_pkg::PH_OPENING;
                end
            end
            bls_pkg::PH_REJECT:
            begin
                if (expired)
                    nxt.phase = bls_pkg::PH_IDLE;
            end
            bls_pkg::PH_OPENING:
            begin
                if (expired)
                begin
                    nxt.countdown = bls_pkg::load_timer(cfg.hold_ticks);
                    nxt.phase     = bls_pkg::PH_OPEN;
                end
            end
            bls_pkg::PH_OPEN:
            begin
                if (loop_present)
                begin
                    nxt.countdown = bls_pkg::load_timer(cfg.pass_limit);
                    nxt.phase     = bls_pkg::PH_PASSING;
                end
                else if (expired)
                begin
                    close_p       = 1'b1;
                    nxt.countdown = bls_pkg::load_timer(cfg.travel_ticks);
                    nxt.phase     = bls_pkg::PH_CLOSING;
                end
            end
            bls_pkg::PH_PASSING:
            begin
                if (!loop_present)
                begin
                    nxt.pass_counter = cur.pass_counter + 1'b1;
                    close_p          = 1'b1;
                    nxt.countdown    = bls_pkg::load_timer(cfg.travel_ticks);
                    nxt.phase        = bls_pkg::PH_CLOSING;
                end
                else if (expired)
                begin
                    close_p         = 1'b1;
                    nxt.fault_latch = 1'b1;
                    nxt.phase       = bls_pkg::PH_TIMEOUT;
                end
            end
            bls_pkg::PH_CLOSING:
            begin
                if (expired)
                    nxt.phase = bls_pkg::PH_IDLE;
            end
            bls_pkg::PH_TIMEOUT:
            begin
                if (!loop_present)
                begin
                    nxt.fault_latch = 1'b0;
                    nxt.phase       = bls_pkg::PH_IDLE;
                end
            end
            default:
            begin
                nxt.phase = bls_pkg::PH_IDLE;
            end
        endcase

        res.open_pulse      = open_p;
        res.close_pulse     = close_p;
        res.command_channel = (open_p || close_p) ? cfg.barrier_channel : 4'd0;
        res.lane_state      = nxt.phase;
        res.passes_done     = bls_pkg::passes_field_t'(nxt.pass_counter);
        res.fault           = nxt.fault_latch;
    end

endmodule

// ===== hw/rtl/barrier_lane_sequencer_top.sv =====
// Barrier lane sequencer. Each accepted tick item advances the lane sequencer by one
// step and yields exactly one result item, registered on the result channel. One tick
// is taken per clock cycle: the whole step is a short decode between the lane state
// registers and the result register, and a new tick is accepted whenever the result
// register is empty or being taken in the same cycle. The user must write configuration
// registers through cfg_wr_en/cfg_index/cfg_data only while the lane is idle; the block
// does not enforce this. Indexes beyond the register list are ignored.
module barrier_lane_sequencer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bls_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bls_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    bls_tick_if.sink                             tick,
    bls_result_if.source                         result
);

    bls_pkg::cfg_t        cfg_reg;
    bls_pkg::lane_state_t lane_reg;
    bls_pkg::lane_state_t lane_next;
    bls_pkg::result_t     res_reg;
    bls_pkg::result_t     res_next;
    logic                 res_valid_reg;
    logic                 tick_take;

    assign tick.ready = !res_valid_reg || result.ready;
    assign tick_take  = tick.valid && tick.ready;

    bls_step u_step (
        .cfg            (cfg_reg),
        .cur            (lane_reg),
        .loop_present   (tick.loop_present),
        .lot_free_count (tick.lot_free_count),
        .nxt            (lane_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_entry_lane   <= 1'b0;
            cfg_reg.barrier_channel <= 4'd0;
            cfg_reg.settle_ticks    <= bls_pkg::SETTLE_RESET;
            cfg_reg.travel_ticks    <= bls_pkg::TRAVEL_RESET;
            cfg_reg.hold_ticks      <= bls_pkg::HOLD_RESET;
            cfg_reg.pass_limit      <= bls_pkg::PASS_TO_RESET;
            cfg_reg.reject_dwell    <= bls_pkg::REJECT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bls_pkg::REG_IS_ENTRY:     cfg_reg.is_entry_lane   <= cfg_data[0];
                bls_pkg::REG_CHANNEL:      cfg_reg.barrier_channel <= cfg_data[3:0];
                bls_pkg::REG_SETTLE:       cfg_reg.settle_ticks    <= cfg_data;
                bls_pkg::REG_TRAVEL:       cfg_reg.travel_ticks    <= cfg_data;
                bls_pkg::REG_HOLD:         cfg_reg.hold_ticks      <= cfg_data;
                bls_pkg::REG_PASS_TIMEOUT: cfg_reg.pass_limit      <= cfg_data;
                bls_pkg::REG_REJECT:       cfg_reg.reject_dwell    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.phase        <= bls_pkg::PH_IDLE;
            lane_reg.countdown    <= '0;
            lane_reg.pass_counter <= '0;
            lane_reg.fault_latch  <= 1'b0;
            res_valid_reg         <= 1'b0;
        end
        else
        begin
            if (tick_take)
            begin
                lane_reg      <= lane_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_take)
            res_reg <= res_next;
    end

    assign result.valid           = res_valid_reg;
    assign result.open_pulse      = res_reg.open_pulse;
    assign result.close_pulse     = res_reg.close_pulse;
    assign result.command_channel = res_reg.command_channel;
    assign result.lane_state      = res_reg.lane_state;
    assign result.passes_done     = res_reg.passes_done;
    assign result.fault           = res_reg.fault;

endmodule

// ===== hw/rtl/bls_checker.sv =====
module bls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        open_pulse,
    input logic        close_pulse,
    input logic [3:0]  command_channel,
    input logic [3:0]  lane_state,
    input logic        fault
);

    // a tick never both opens and closes
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(open_pulse && close_pulse))
        else $error("open and close pulse together");

    // channel only addresses the servo when a command goes out
    a_channel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !open_pulse && !close_pulse) |-> (command_channel == 4'd0))
        else $error("channel set without a pulse");

    // latched fault lives only in the timeout state
    a_fault_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && fault) |-> (lane_state == bls_pkg::PH_TIMEOUT))
        else $error("fault outside timeout");

    // an open command always lands the lane in opening
    a_open_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && open_pulse) |-> (lane_state == bls_pkg::PH_OPENING))
        else $error("open pulse without opening state");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(lane_state) && $stable(fault)))
        else $error("stalled result changed");

endmodule

bind barrier_lane_sequencer_top bls_checker u_bls_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .open_pulse      (result.open_pulse),
    .close_pulse     (result.close_pulse),
    .command_channel (result.command_channel),
    .lane_state      (result.lane_state),
    .fault           (result.fault)
);

// ===== verif/barrier_lane_checker.sv =====
`timescale 1ns / 100ps

module barrier_lane_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    bls_tick_if                                 tick,
    bls_result_if                               result,
    output int                                  fail_count,
    output int                                  pending
);

    bls_pkg::cfg_t        lane_cfg;
    bls_pkg::lane_state_t lane;
    bls_pkg::result_t     expected_q[$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // One tick of the lane: timer first, then the sequencer.
    function automatic bls_pkg::result_t advance_lane(logic loop, logic [7:0] free_count);
        bls_pkg::result_t r;
        logic             lot_full;
        r = '0;
        lot_full = (free_count == 8'd0);
        if (lane.countdown != '0)
            lane.countdown = lane.countdown - 1'b1;
        case (lane.phase)
            bls_pkg::PH_IDLE:
            begin
                if (loop)
                begin
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.settle_ticks);
                    lane.phase = bls_pkg::PH_WAIT;
                end
            end
            bls_pkg::PH_WAIT:
            begin
                if (lane.countdown == '0)
                    lane.phase = bls_pkg::PH_AUTH;
            end
            bls_pkg::PH_AUTH:
            begin
                if (lane_cfg.is_entry_lane && lot_full)
                begin
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.reject_dwell);
                    lane.phase = bls_pkg::PH_REJECT;
                end
                else
                begin
                    r.open_pulse = 1'b1;
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.travel_ticks);
                    lane.phase = bls_pkg::PH_OPENING;
                end
            end
            bls_pkg::PH_REJECT:
            begin
                if (lane.countdown == '0)
                    lane.phase = bls_pkg::PH_IDLE;
            end
            bls_pkg::PH_OPENING:
            begin
                if (lane.countdown == '0)
                begin
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.hold_ticks);
                    lane.phase = bls_pkg::PH_OPEN;
                end
            end
            bls_pkg::PH_OPEN:
            begin
                if (loop)
                begin
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.pass_limit);
                    lane.phase = bls_pkg::PH_PASSING;
                end
                else if (lane.countdown == '0)
                begin
                    r.close_pulse = 1'b1;
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.travel_ticks);
                    lane.phase = bls_pkg::PH_CLOSING;
                end
            end
            bls_pkg::PH_PASSING:
            begin
                if (!loop)
                begin
                    lane.pass_counter = lane.pass_counter + 1'b1;
                    r.close_pulse = 1'b1;
                    lane.countdown = bls_pkg::timer_t'(lane_cfg.travel_ticks);
                    lane.phase = bls_pkg::PH_CLOSING;
                end
                else if (lane.countdown == '0)
                begin
                    // vehicle sat on the loop too long: close anyway and latch fault
                    r.close_pulse = 1'b1;
                    lane.fault_latch = 1'b1;
                    lane.phase = bls_pkg::PH_TIMEOUT;
                end
            end
            bls_pkg::PH_CLOSING:
            begin
                if (lane.countdown == '0)
                    lane.phase = bls_pkg::PH_IDLE;
            end
            bls_pkg::PH_TIMEOUT:
            begin
                if (!loop)
                begin
                    lane.fault_latch = 1'b0;
                    lane.phase = bls_pkg::PH_IDLE;
                end
            end
            default:
            begin
                lane.phase = bls_pkg::PH_IDLE;
            end
        endcase
        if (r.open_pulse || r.close_pulse)
            r.command_channel = lane_cfg.barrier_channel;
        r.lane_state = lane.phase;
        r.passes_done = bls_pkg::passes_field_t'(lane.pass_counter);
        r.fault = lane.fault_latch;
        return r;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        bls_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            $error("result item with no tick item outstanding");
            fail_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("open_pulse", 16'(want.open_pulse), 16'(result.open_pulse));
            check_field("close_pulse", 16'(want.close_pulse), 16'(result.close_pulse));
            check_field("command_channel", 16'(want.command_channel),
                        16'(result.command_channel));
            check_field("lane_state", 16'(want.lane_state), 16'(result.lane_state));
            check_field("passes_done", want.passes_done, result.passes_done);
            check_field("fault", 16'(want.fault), 16'(result.fault));
        end
    endtask

    task automatic write_cfg(logic [bls_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [bls_pkg::CFG_DATA_WIDTH-1:0] value);
        case (idx)
            bls_pkg::REG_IS_ENTRY:     lane_cfg.is_entry_lane = value[0];
            bls_pkg::REG_CHANNEL:      lane_cfg.barrier_channel = value[3:0];
            bls_pkg::REG_SETTLE:       lane_cfg.settle_ticks = value;
            bls_pkg::REG_TRAVEL:       lane_cfg.travel_ticks = value;
            bls_pkg::REG_HOLD:         lane_cfg.hold_ticks = value;
            bls_pkg::REG_PASS_TIMEOUT: lane_cfg.pass_limit = value;
            bls_pkg::REG_REJECT:       lane_cfg.reject_dwell = value;
            default:                   ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_cfg.is_entry_lane = 1'b0;
            lane_cfg.barrier_channel = 4'd0;
            lane_cfg.settle_ticks = bls_pkg::SETTLE_RESET;
            lane_cfg.travel_ticks = bls_pkg::TRAVEL_RESET;
            lane_cfg.hold_ticks = bls_pkg::HOLD_RESET;
            lane_cfg.pass_limit = bls_pkg::PASS_TO_RESET;
            lane_cfg.reject_dwell = bls_pkg::REJECT_RESET;
            lane.phase = bls_pkg::PH_IDLE;
            lane.countdown = '0;
            lane.pass_counter = '0;
            lane.fault_latch = 1'b0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
                check_result();
            if (cfg_wr_en)
                write_cfg(cfg_index, cfg_data);
            if (tick.valid && tick.ready)
                expected_q.push_back(advance_lane(tick.loop_present, tick.lot_free_count));
            pending = expected_q.size();
        end
    end

endmodule

// ===== verif/barrier_lane_sequencer_top_test.sv =====
`timescale 1ns / 100ps

module barrier_lane_sequencer_top_test;

    localparam logic [bls_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
    localparam int LONG_STALL_CYCLES = 60;
    localparam int DIRECTED_LEN = 27;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en;
    logic [bls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [bls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    int fail_count;
    int pending;

    bit sender_gaps;
    bit receiver_gaps;
    bit long_stall;

    // reject on a full lot, a normal pass, an open with no vehicle, a pass timeout
    bit directed_loop [DIRECTED_LEN] = '{1, 1, 0, 0,
                                         1, 1, 1, 0, 1, 0, 0,
                                         1, 1, 0, 0, 0, 0, 0,
                                         1, 1, 1, 1, 1, 1, 1, 1, 0};
    logic [7:0] directed_free [DIRECTED_LEN] = '{0, 0, 0, 0,
                                                 255, 255, 255, 255, 255, 255, 255,
                                                 128, 128, 128, 128, 128, 128, 128,
                                                 1, 1, 1, 1, 1, 1, 1, 1, 1};

    bls_tick_if   tick();
    bls_result_if result();

    barrier_lane_sequencer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .result    (result)
    );

    barrier_lane_checker lane_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick       (tick),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                result.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
                long_stall = 1'b0;
            end
            result.ready <= !(receiver_gaps && $urandom_range(0, 99) < 38);
        end
    end

    function automatic logic [7:0] random_free();
        if ($urandom_range(0, 3) == 0)
            return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_tick(bit loop, logic [7:0] free_count);
        while (sender_gaps && $urandom_range(0, 99) < 38)
        begin
            @(negedge clk);
            tick.valid <= 1'b0;
            tick.loop_present <= 1'($urandom_range(0, 1));
            tick.lot_free_count <= 8'($urandom_range(0, 255));
        end
        @(negedge clk);
        tick.valid <= 1'b1;
        tick.loop_present <= loop;
        tick.lot_free_count <= free_count;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        tick.valid <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [bls_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [bls_pkg::CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic apply_settings(logic [15:0] entry, logic [15:0] channel, logic [15:0] settle,
                                  logic [15:0] travel, logic [15:0] hold, logic [15:0] pass_to,
                                  logic [15:0] reject);
        wait_drained();
        write_reg(bls_pkg::REG_IS_ENTRY, entry);
        write_reg(bls_pkg::REG_CHANNEL, channel);
        write_reg(bls_pkg::REG_SETTLE, settle);
        write_reg(bls_pkg::REG_TRAVEL, travel);
        write_reg(bls_pkg::REG_HOLD, hold);
        write_reg(bls_pkg::REG_PASS_TIMEOUT, pass_to);
        write_reg(bls_pkg::REG_REJECT, reject);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // loop level held in runs so vehicles settle, pass and leave; some noise mixed in
    task automatic run_traffic(int count, int max_run);
        bit level;
        int run_left;
        level = 1'b0;
        run_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                level = !level;
                run_left = $urandom_range(1, max_run);
            end
            run_left--;
            if ($urandom_range(0, 99) < 12)
                send_tick(1'($urandom_range(0, 1)), random_free());
            else
                send_tick(level, random_free());
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tick.valid = 1'b0;
        tick.loop_present = 1'b0;
        tick.lot_free_count = 8'd0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        long_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset timings: long dwell, mostly idle/wait/authorise
        run_traffic(120, 40);
        wait_drained();

        // unused index must be ignored; high data bits dropped on the narrow registers
        write_reg(REG_SPARE, 16'hFFFF);
        apply_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1);
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_tick(directed_loop[i], directed_free[i]);

        // zero loads: every timer expires on the following tick
        apply_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_traffic(70, 4);

        // back-to-back stretch; result side holds off so the input stalls
        apply_settings(16'd1, 16'd9, 16'd2, 16'd1, 16'd3, 16'd4, 16'd2);
        wait_drained();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        long_stall = 1'b1;
        run_traffic(110, 6);
        wait_drained();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;

        for (int p = 0; p < 7; p++)
        begin
            apply_settings(16'($urandom_range(0, 1)), 16'($urandom_range(0, 15)),
                           16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 4)));
            run_traffic(110, $urandom_range(3, 10));
        end

        apply_settings(16'd1, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(40, 8);

        wait_drained();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bls_pkg.sv
hw/rtl/bls_if.sv
hw/rtl/bls_step.sv
hw/rtl/barrier_lane_sequencer_top.sv
hw/rtl/bls_checker.sv
verif/barrier_lane_checker.sv
verif/barrier_lane_sequencer_top_test.sv
